// ===== hdl/variance_stdev_accumulator_assert.svh =====
// Assertion macros for the variance / standard deviation accumulator.
// Used by the bound port checker; needs no other file.
`ifndef VARIANCE_STDEV_ACCUMULATOR_ASSERT_SVH
`define VARIANCE_STDEV_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define VSA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/vsa_pkg.sv =====
// Shared types and constants of the variance / standard deviation accumulator.
// No dependencies; imported by every other file but vsa_alu and the assertion header.
package vsa_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 24;
  localparam int RESULT_W = 49;
  localparam int STATUS_W = 2;
  localparam int ROOT_W   = (RESULT_W + 1) / 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // Smallest set that a sample divisor accepts
  localparam int MIN_SAMPLE_SET = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIVISOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAKE_ROOT      = 1'd1;

  // Closing sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_B,
    ST_LOAD_A,
    ST_MUL_A,
    ST_SUB,
    ST_DIV,
    ST_SAT,
    ST_SQRT,
    ST_WRITE
  } state_t;

endpackage

// ===== hdl/vsa_if.sv =====
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on vsa_pkg for the field widths.
interface vsa_in_if
  import vsa_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       has_value;
  logic                       last_of_set;

  modport source (output valid, sample_value, has_value, last_of_set, input ready);
  modport sink   (input valid, sample_value, has_value, last_of_set, output ready);
endinterface

interface vsa_out_if
  import vsa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result_value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// ===== hdl/vsa_accum.sv =====
// Per-sample accumulation of count, sum and sum of squares.
// Depends on vsa_pkg; instantiated by the top level.
module vsa_accum
  import vsa_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  logic                       clear,
  output logic [$clog2(MAX_SAMPLES+1)-1:0]          count,
  output logic signed [SAMPLE_W+$clog2(MAX_SAMPLES+1)-1:0] sum,
  output logic [2*SAMPLE_W-2+$clog2(MAX_SAMPLES+1)-1:0]    square_sum,
  output logic                       overflowed
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_W - 2 + CNT_W;

  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_sum_r, sq_sum_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [2*SAMPLE_W-1:0]   sq_r, sq_nxt;
  logic                    pend_r, pend_nxt;
  logic [SAMPLE_W-1:0]     mag;
  logic                    full;

  // Magnitude of the sample; the most negative value still fits unsigned
  assign mag  = sample_value[SAMPLE_W-1] ? SAMPLE_W'(-sample_value) : SAMPLE_W'(sample_value);
  assign full = (cnt_r == CNT_W'(MAX_SAMPLES));

  // Count and sum in the beat cycle, square sum in the cycle after
  always_comb begin
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    ovf_nxt    = ovf_r;
    sq_nxt     = sq_r;
    pend_nxt   = 1'b0;
    sq_sum_nxt = pend_r ? sq_sum_r + SQ_W'(sq_r) : sq_sum_r;
    if (clear) begin
      cnt_nxt    = '0;
      sum_nxt    = '0;
      sq_sum_nxt = '0;
      ovf_nxt    = 1'b0;
    end else if (take) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        sum_nxt  = sum_r + {{(SUM_W-SAMPLE_W){sample_value[SAMPLE_W-1]}}, sample_value};
        sq_nxt   = mag * mag;
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sum_r    <= '0;
      sq_sum_r <= '0;
      ovf_r    <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      sq_sum_r <= sq_sum_nxt;
      ovf_r    <= ovf_nxt;
      pend_r   <= pend_nxt;
    end
  end

  // Square product holds no reset
  always_ff @(posedge clk) begin
    sq_r <= sq_nxt;
  end

  assign count      = cnt_r;
  assign sum        = sum_r;
  assign square_sum = sq_sum_r;
  assign overflowed = ovf_r;

endmodule

// ===== hdl/vsa_alu.sv =====
// Shared add/subtract unit of the closing sequencer.
// No package dependency; instantiated by vsa_engine.
module vsa_alu #(
  parameter int W = 72
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         sub,
  output logic [W-1:0] sum,
  output logic         borrow
);

  logic [W:0] full;

  // Subtract as a plus inverted b plus one; no carry out means a borrow
  assign full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
  assign sum    = full[W-1:0];
  assign borrow = sub & ~full[W];

endmodule

// ===== hdl/vsa_engine.sv =====
// Closing sequencer: shift-add multiplies, restoring divide and digit square root,
// all on one shared adder, plus the result register. Depends on vsa_pkg, vsa_alu.
module vsa_engine
  import vsa_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic sample_div,
  input  logic take_root,
  input  logic [$clog2(MAX_SAMPLES+1)-1:0]                 count,
  input  logic signed [SAMPLE_W+$clog2(MAX_SAMPLES+1)-1:0] sum,
  input  logic [2*SAMPLE_W-2+$clog2(MAX_SAMPLES+1)-1:0]    square_sum,
  input  logic overflowed,
  output logic idle,
  output logic clear,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RESULT_W-1:0] out_result,
  output logic [STATUS_W-1:0] out_status
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;
  localparam int MW     = SUM_W - 1;
  localparam int NUM_W  = SQ_W + CNT_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int ITER_W = $clog2(NUM_W + 1);

  state_t state_r, state_nxt;

  logic [NUM_W-1:0]    acc_r, num_r;
  logic [SQ_W-1:0]     mcand_r;
  logic [MW-1:0]       mplier_r;
  logic [DEN_W-1:0]    den_r;
  logic [ROOT_W-1:0]   root_r;
  logic [RESULT_W-1:0] res_r;
  logic [STATUS_W-1:0] st_r;
  logic [ITER_W-1:0]   iter_r;
  logic                out_valid_r;
  logic [RESULT_W-1:0] out_result_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [NUM_W-1:0]    alu_a, alu_b, alu_sum;
  logic                alu_sub, alu_borrow;
  logic                last_iter, out_free, too_few, load_out;
  logic [CNT_W-1:0]    divisor;
  logic [MW-1:0]       smag;
  logic [RESULT_W-1:0] sat;
  logic [ROOT_W-1:0]   root_step;

  vsa_alu #(.W(NUM_W)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .sum    (alu_sum),
    .borrow (alu_borrow)
  );

  assign last_iter = (iter_r == ITER_W'(1));
  assign out_free  = !out_valid_r || out_ready;
  assign too_few   = sample_div ? (count < CNT_W'(MIN_SAMPLE_SET)) : (count == '0);
  assign divisor   = sample_div ? count - CNT_W'(1) : count;
  assign smag      = sum[SUM_W-1] ? MW'(-sum) : MW'(sum);
  assign sat       = (|num_r[NUM_W-1:RESULT_W]) ? '1 : num_r[RESULT_W-1:0];
  assign root_step = {root_r[ROOT_W-2:0], !alu_borrow};

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_PREP;
      ST_PREP:   state_nxt = (overflowed || too_few) ? ST_WRITE : ST_MUL_B;
      ST_MUL_B:  if (last_iter) state_nxt = ST_LOAD_A;
      ST_LOAD_A: state_nxt = ST_MUL_A;
      ST_MUL_A:  if (last_iter) state_nxt = ST_SUB;
      ST_SUB:    state_nxt = ST_DIV;
      ST_DIV:    if (last_iter) state_nxt = ST_SAT;
      ST_SAT:    state_nxt = take_root ? ST_SQRT : ST_WRITE;
      ST_SQRT:   if (last_iter) state_nxt = ST_WRITE;
      ST_WRITE:  if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Adder operands and handshake controls
  always_comb begin
    alu_a    = '0;
    alu_b    = '0;
    alu_sub  = 1'b0;
    idle     = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        idle = 1'b1;
      end
      ST_MUL_B, ST_MUL_A: begin
        alu_a = {acc_r[NUM_W-2:0], 1'b0};
        alu_b = mplier_r[MW-1] ? NUM_W'(mcand_r) : '0;
      end
      ST_SUB: begin
        alu_a   = acc_r;
        alu_b   = num_r;
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {acc_r[NUM_W-2:0], num_r[NUM_W-1]};
        alu_b   = NUM_W'(den_r);
        alu_sub = 1'b1;
      end
      ST_SQRT: begin
        alu_a   = {acc_r[NUM_W-3:0], num_r[2*ROOT_W-1 -: 2]};
        alu_b   = NUM_W'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      ST_WRITE: begin
        load_out = out_free;
      end
      default: begin
        idle = 1'b0;
      end
    endcase
  end

  assign clear = load_out;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_PREP:   iter_r <= ITER_W'(MW);
        ST_LOAD_A: iter_r <= ITER_W'(CNT_W);
        ST_SUB:    iter_r <= ITER_W'(NUM_W);
        ST_SAT:    iter_r <= ITER_W'(ROOT_W);
        ST_MUL_B, ST_MUL_A, ST_DIV, ST_SQRT: iter_r <= iter_r - ITER_W'(1);
        default:   iter_r <= iter_r;
      endcase
    end
  end

  // Datapath registers advance with the sequencer
  always_ff @(posedge clk) begin
    case (state_r)
      ST_PREP: begin
        den_r    <= count * divisor;
        mcand_r  <= SQ_W'(smag);
        mplier_r <= smag;
        acc_r    <= '0;
        res_r    <= '0;
        if (overflowed) begin
          st_r <= STATUS_OVERFLOW;
        end else if (too_few) begin
          st_r <= STATUS_DIV_ZERO;
        end else begin
          st_r <= STATUS_OK;
        end
      end
      ST_MUL_B, ST_MUL_A: begin
        acc_r    <= alu_sum;
        mplier_r <= {mplier_r[MW-2:0], 1'b0};
      end
      ST_LOAD_A: begin
        num_r    <= acc_r;
        acc_r    <= '0;
        mcand_r  <= square_sum;
        mplier_r <= {count, {(MW-CNT_W){1'b0}}};
      end
      ST_SUB: begin
        num_r <= alu_borrow ? '0 : alu_sum;
        acc_r <= '0;
      end
      ST_DIV: begin
        // Keep the shifted remainder when the divisor does not fit
        acc_r <= alu_borrow ? alu_a : alu_sum;
        num_r <= {num_r[NUM_W-2:0], !alu_borrow};
      end
      ST_SAT: begin
        num_r  <= NUM_W'(sat);
        res_r  <= sat;
        acc_r  <= '0;
        root_r <= '0;
      end
      ST_SQRT: begin
        // Keep the shifted remainder when the trial value does not fit
        acc_r  <= alu_borrow ? alu_a : alu_sum;
        num_r  <= {num_r[NUM_W-3:0], 2'b00};
        root_r <= root_step;
        res_r  <= RESULT_W'(root_step);
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
    if (load_out) begin
      out_result_r <= res_r;
      out_status_r <= st_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

endmodule

// ===== hdl/variance_stdev_accumulator.sv =====
// Variance / standard deviation accumulator. A sample beat that does not close
// its set is taken back to back while the sequencer is idle. A closing beat
// runs the closing sequence on one shared adder before the next beat is taken:
// a shift-add square of the sum, a shift-add product of count and sum of
// squares, a restoring divide by n*d (one quotient bit a cycle over the
// numerator width) and, in root mode, a two-bits-a-cycle square root, plus
// setup and hand-off. A set that closes with too few samples or with a count
// overflow skips the arithmetic and goes straight to the hand-off. The
// finished result sits in an output register and sample beats of the next set
// are taken while it waits.
module variance_stdev_accumulator
  import vsa_pkg::*;
#(
  parameter int MAX_SAMPLES = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vsa_in_if.sink                in_ch,
  vsa_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = SAMPLE_W + CNT_W;
  localparam int SQ_W  = 2 * SAMPLE_W - 2 + CNT_W;

  logic sample_div_r, take_root_r;
  logic in_beat, idle, clear;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         square_sum;
  logic                    overflowed;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_div_r <= 1'b1;
      take_root_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_DIVISOR: sample_div_r <= cfg_wdata[0];
        CFG_TAKE_ROOT:      take_root_r  <= cfg_wdata[0];
        default:            sample_div_r <= sample_div_r;
      endcase
    end
  end

  assign in_ch.ready = idle;
  assign in_beat     = in_ch.valid && idle;

  vsa_accum #(.MAX_SAMPLES(MAX_SAMPLES)) u_accum (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_beat && in_ch.has_value),
    .sample_value (in_ch.sample_value),
    .clear        (clear),
    .count        (count),
    .sum          (sum),
    .square_sum   (square_sum),
    .overflowed   (overflowed)
  );

  vsa_engine #(.MAX_SAMPLES(MAX_SAMPLES)) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_beat && in_ch.last_of_set),
    .sample_div (sample_div_r),
    .take_root  (take_root_r),
    .count      (count),
    .sum        (sum),
    .square_sum (square_sum),
    .overflowed (overflowed),
    .idle       (idle),
    .clear      (clear),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.result_value),
    .out_status (out_ch.status)
  );

endmodule

// ===== hdl/vsa_checker.sv =====
// Port-level checks of the accumulator, bound to the top level.
// Depends on vsa_pkg and variance_stdev_accumulator_assert.svh.
`include "variance_stdev_accumulator_assert.svh"

module vsa_checker
  import vsa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                in_last,
  input logic                out_valid,
  input logic                out_ready,
  input logic [RESULT_W-1:0] out_result,
  input logic [STATUS_W-1:0] out_status
);

  // A stalled result beat stays offered
  `VSA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

  // A closing beat starts the closing sequence, so the input stalls next cycle
  `VSA_ASSERT_NEXT(a_close_stall, clk, rst_n, in_valid && in_ready && in_last, !in_ready, "input taken right after a closing beat")

  // Error results carry a zero value
  `VSA_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (out_status != STATUS_OK), out_result == '0, "error result with nonzero value")

endmodule

bind variance_stdev_accumulator vsa_checker u_vsa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_last    (in_ch.last_of_set),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result_value),
  .out_status (out_ch.status)
);

// ===== test/tb.sv =====
// Testbench for variance_stdev_accumulator: drives sample sets over the valid/ready
// channels, writes the mode registers between phases and checks every result beat.
// Depends on vsa_pkg, the vsa_if channel interfaces and the accumulator RTL.
module tb;
  import vsa_pkg::*;

  localparam int MAX_SAMPLES  = 4096;
  localparam int CLOSE_CYCLES = 160;   // longest closing sequence plus margin
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_BEATS  = 265;
  localparam int LONG_SET     = 60;
  localparam logic [127:0] RESULT_MAX = (128'd1 << RESULT_W) - 128'd1;

  typedef struct packed {
    logic [RESULT_W-1:0] result_value;
    logic [STATUS_W-1:0] status;
  } stat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                has_value;
    logic                last_of_set;
    logic                typed;       // expected result given in the row
    logic [RESULT_W-1:0] exp_value;
    logic [STATUS_W-1:0] exp_status;
  } beat_t;

  // Directed sets, run with the reset modes (sample divisor, variance out)
  localparam beat_t DIRECTED [17] = '{
    // empty set closed by an empty beat
    '{24'h000000, 1'b0, 1'b1, 1'b1, 49'd0, STATUS_DIV_ZERO},
    // single sample is too few for the sample divisor
    '{24'h000500, 1'b1, 1'b1, 1'b1, 49'd0, STATUS_DIV_ZERO},
    // 1.0 and 3.0, an ignored beat between, closed by an empty beat: 2.0
    '{24'h000100, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'h123456, 1'b0, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'h000300, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'hABCDEF, 1'b0, 1'b1, 1'b1, 49'h20000, STATUS_OK},
    // largest and smallest sample
    '{24'h7FFFFF, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'h800000, 1'b1, 1'b1, 1'b0, 49'd0, STATUS_OK},
    // constant set has zero spread
    '{24'hFFFF00, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'hFFFF00, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'hFFFF00, 1'b1, 1'b1, 1'b1, 49'd0, STATUS_OK},
    // lopsided extremes
    '{24'h800000, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'h800000, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'h7FFFFF, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'h000000, 1'b1, 1'b1, 1'b0, 49'd0, STATUS_OK},
    // smallest nonzero steps either side of zero
    '{24'h000001, 1'b1, 1'b0, 1'b0, 49'd0, STATUS_OK},
    '{24'hFFFFFF, 1'b1, 1'b1, 1'b0, 49'd0, STATUS_OK}
  };

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vsa_in_if  in_if ();
  vsa_out_if out_if ();

  variance_stdev_accumulator #(.MAX_SAMPLES(MAX_SAMPLES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor state: running set statistics and the mode registers
  int          set_count;
  longint      set_sum;
  logic [63:0] set_sq_sum;
  bit          set_overflow;
  bit          div_by_n_minus_1;
  bit          root_mode;

  stat_t expected_stats [$];
  int    beats_sent = 0;
  int    faults = 0;
  bit    hold_req = 1'b0;
  bit    send_idle = 1'b1;
  bit    recv_idle = 1'b1;
  bit    calm = 1'b0;

  // Append one expectation behind the ones still waiting
  function automatic void queue_result(input stat_t st);
    expected_stats = {expected_stats, st};
  endfunction

  function automatic void clear_set();
    set_count    = 0;
    set_sum      = 0;
    set_sq_sum   = '0;
    set_overflow = 1'b0;
  endfunction

  function automatic logic [RESULT_W-1:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] rem, root, probe;
    rem   = v;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root[RESULT_W-1:0];
  endfunction

  // Fold one accepted beat into the set; on a close, compute the spread
  function automatic bit fold_beat(input beat_t b, output stat_t st);
    longint       x, mag, n, d;
    logic [127:0] num, sum_sq, quot;
    st = '0;
    if (b.has_value) begin
      if (set_count >= MAX_SAMPLES) begin
        set_overflow = 1'b1;
      end else begin
        x   = longint'(signed'(b.sample_value));
        mag = (x < 0) ? -x : x;
        set_count++;
        set_sum    = set_sum + x;
        set_sq_sum = set_sq_sum + 64'(mag * mag);
      end
    end
    if (!b.last_of_set) return 1'b0;
    if (set_overflow) begin
      st.status = STATUS_OVERFLOW;
    end else if (div_by_n_minus_1 ? (set_count < MIN_SAMPLE_SET) : (set_count == 0)) begin
      st.status = STATUS_DIV_ZERO;
    end else begin
      n      = set_count;
      d      = div_by_n_minus_1 ? n - 1 : n;
      mag    = (set_sum < 0) ? -set_sum : set_sum;
      num    = 128'(n) * 128'(set_sq_sum);
      sum_sq = 128'(mag) * 128'(mag);
      num    = (num < sum_sq) ? 128'd0 : num - sum_sq;
      quot   = num / 128'(n * d);
      if (quot > RESULT_MAX) quot = RESULT_MAX;
      st.status       = STATUS_OK;
      st.result_value = root_mode ? floor_sqrt(quot[63:0]) : quot[RESULT_W-1:0];
    end
    clear_set();
    return 1'b1;
  endfunction

  function automatic void note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return SAMPLE_W'($urandom_range(0, 2047)) - 24'd1024;
      3:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int set_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 0;
    if (pick < 16) return 1;
    if (pick < 90) return $urandom_range(2, 12);
    return $urandom_range(13, 60);
  endfunction

  // Offer one beat from a falling edge; return at the falling edge after it is taken
  task automatic send_beat(input beat_t b);
    stat_t st;
    if (send_idle && !calm && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_value <= b.sample_value;
    in_if.has_value    <= b.has_value;
    in_if.last_of_set  <= b.last_of_set;
    do @(posedge clk); while (!in_if.ready);
    beats_sent++;
    if (fold_beat(b, st)) begin
      if (b.typed) queue_result({b.exp_value, b.exp_status});
      else queue_result(st);
    end
    @(negedge clk);
  endtask

  // Random set of n counted samples, with ignored beats sprinkled in
  task automatic run_set(input int n, input bit empty_close);
    beat_t b;
    send_idle = !calm && ($urandom_range(0, 3) != 0);
    recv_idle = !calm && ($urandom_range(0, 3) != 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 6) == 0) begin
        b = '0;
        b.sample_value = SAMPLE_W'($urandom);
        send_beat(b);
      end
      b = '0;
      b.sample_value = draw_sample();
      b.has_value    = 1'b1;
      b.last_of_set  = (k == n - 1) && !empty_close;
      send_beat(b);
    end
    if (n == 0 || empty_close) begin
      b = '0;
      b.sample_value = SAMPLE_W'($urandom);
      b.last_of_set  = 1'b1;
      send_beat(b);
    end
  endtask

  // Long set of mostly extreme samples; past MAX_SAMPLES it overflows
  task automatic run_long_set(input int n);
    beat_t b;
    for (int k = 0; k < n; k++) begin
      b = '0;
      if (k % 5 == 4) b.sample_value = draw_sample();
      else b.sample_value = (k % 2 == 1) ? 24'h800000 : 24'h7FFFFF;
      b.has_value   = 1'b1;
      b.last_of_set = (k == n - 1);
      send_beat(b);
    end
  endtask

  task automatic random_sets(input int goal);
    int stop_at;
    stop_at = beats_sent + goal;
    while (beats_sent < stop_at) run_set(set_length(), $urandom_range(0, 3) == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SAMPLE_DIVISOR) div_by_n_minus_1 = val;
    else root_mode = val;
  endtask

  // Drop valid, wait for every result, then let the closing logic go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk);
    repeat (CLOSE_CYCLES) @(negedge clk);
  endtask

  // Result side: random stall bursts, one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (recv_idle && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    stat_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_stats.size() == 0) begin
        note_fault($sformatf("unexpected result: value %0d status %0d",
                             out_if.result_value, out_if.status));
      end else begin
        want = expected_stats.pop_front();
        if (out_if.result_value !== want.result_value)
          note_fault($sformatf("result_value expected %0d got %0d",
                               want.result_value, out_if.result_value));
        if (out_if.status !== want.status)
          note_fault($sformatf("status expected %0d got %0d", want.status, out_if.status));
      end
    end
  end

  initial begin : watchdog
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_SAMPLE_DIVISOR;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.sample_value = '0;
    in_if.has_value    = 1'b0;
    in_if.last_of_set  = 1'b0;
    div_by_n_minus_1   = 1'b1;
    root_mode          = 1'b0;
    clear_set();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Reset modes: directed rows, a long set of extremes, then random
    foreach (DIRECTED[i]) send_beat(DIRECTED[i]);
    run_long_set(LONG_SET);
    random_sets(PHASE_BEATS);
    settle();

    // Population variance, with the result side held off to back the block up
    write_reg(CFG_SAMPLE_DIVISOR, 1'b0);
    hold_req = 1'b1;
    run_set(0, 1'b0);
    run_set(1, 1'b0);
    random_sets(PHASE_BEATS);
    settle();

    // Population standard deviation
    write_reg(CFG_TAKE_ROOT, 1'b1);
    run_set(0, 1'b0);
    run_set(1, 1'b0);
    random_sets(PHASE_BEATS);
    settle();

    // Sample standard deviation, no idling on either side
    calm = 1'b1;
    write_reg(CFG_SAMPLE_DIVISOR, 1'b1);
    run_set(0, 1'b0);
    run_set(1, 1'b0);
    run_set(2, 1'b0);
    random_sets(PHASE_BEATS);
    settle();

    if (faults == 0 && expected_stats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
